[hdl/byte_run_length_encoder_assert.svh]
// Assertion macros for the byte run-length encoder.
`ifndef BYTE_RUN_LENGTH_ENCODER_ASSERT_SVH
`define BYTE_RUN_LENGTH_ENCODER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define BRLE_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("brle assertion failed");

// Next-cycle implication, checked outside reset
`define BRLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("brle assertion failed");

`endif

[hdl/brle_pkg.sv]
// Shared types and constants of the byte run-length encoder.
package brle_pkg;

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 16;
  localparam int MAX_RUN   = 255;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = 2;
  localparam int Q_CNT_W   = 3;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [LEN_W-1:0]  len_t;

  typedef struct packed {
    byte_t run_count;
    byte_t run_value;
    logic  last_pair;
    logic  too_large;
  } pair_t;

endpackage

[hdl/brle_byte_if.sv]
// Input byte channel.
interface brle_byte_if;
  import brle_pkg::*;

  logic  valid;
  logic  ready;
  byte_t byte_value;

  modport source (output valid, output byte_value, input ready);
  modport sink (input valid, input byte_value, output ready);
endinterface

[hdl/brle_pair_if.sv]
// Output pair channel.
interface brle_pair_if;
  import brle_pkg::*;

  logic  valid;
  logic  ready;
  byte_t run_count;
  byte_t run_value;
  logic  last_pair;
  logic  too_large;

  modport source (output valid, output run_count, output run_value,
                  output last_pair, output too_large, input ready);
  modport sink (input valid, input run_count, input run_value,
                input last_pair, input too_large, output ready);
endinterface

[hdl/brle_cfg_if.sv]
// Configuration write channel carrying the block length.
interface brle_cfg_if;
  import brle_pkg::*;

  logic valid;
  logic ready;
  len_t block_length;

  modport source (output valid, output block_length, input ready);
  modport sink (input valid, input block_length, output ready);
endinterface

[hdl/byte_run_length_encoder.sv]
// Byte run-length encoder: count/value pairs with early stop on poor ratio.
// Each pair is registered into the output queue when its byte is accepted and is driven from the queue head.
// Throughput: one byte per cycle while input ready is set; a byte that closes two pairs pushes both into the queue.
// Input ready is set while the four-word output queue holds two pairs or fewer.
// Reset: block length returns to 1, run state and output queue are cleared.
// Configuration words are taken every cycle.
module byte_run_length_encoder (
  input  logic              clk,
  input  logic              rst,
  brle_cfg_if.sink          cfg,
  brle_byte_if.sink         bytes,
  brle_pair_if.source       pairs
);
  import brle_pkg::*;

  // Block state
  len_t  block_length;
  byte_t cur_value;
  byte_t cur_count;
  len_t  pairs_emitted;
  len_t  item_index;
  logic  stopped;

  byte_t cur_value_next;
  byte_t cur_count_next;
  len_t  pairs_emitted_next;
  len_t  item_index_next;
  logic  stopped_next;

  // Output queue
  pair_t                queue [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;

  logic                 accept;
  logic                 pop;
  len_t                 eff_len;
  logic                 last;
  logic                 over;
  logic                 emit_mid;
  logic                 emit_final;
  pair_t                mid_pair;
  pair_t                final_pair;
  pair_t                res0;
  logic [1:0]           push_n;

  assign cfg.ready   = 1'b1;
  assign bytes.ready = (count <= Q_CNT_W'(Q_DEPTH - 2));
  assign accept      = bytes.valid & bytes.ready;
  assign pop         = pairs.valid & pairs.ready;

  // Encode one byte against the open run
  always_comb begin
    eff_len = (block_length == '0) ? len_t'(1) : block_length;
    last    = ({1'b0, item_index} + 17'd1) >= {1'b0, eff_len};
    over    = {pairs_emitted, 3'b000} > {3'b000, eff_len};

    cur_value_next     = cur_value;
    cur_count_next     = cur_count;
    pairs_emitted_next = pairs_emitted;
    stopped_next       = stopped;
    emit_mid           = 1'b0;
    emit_final         = 1'b0;

    mid_pair.run_count = cur_count;
    mid_pair.run_value = cur_value;
    mid_pair.last_pair = 1'b0;
    mid_pair.too_large = 1'b0;

    if (item_index == '0) begin
      cur_value_next = bytes.byte_value;
      cur_count_next = byte_t'(1);
    end else if (!stopped) begin
      if (over) begin
        // Ratio already too poor: close the block with the open run
        emit_mid           = 1'b1;
        mid_pair.last_pair = 1'b1;
        mid_pair.too_large = {({1'b0, pairs_emitted} + 17'd1), 3'b000} >
                             {4'b0000, eff_len};
        stopped_next       = 1'b1;
      end else if (bytes.byte_value == cur_value && cur_count < byte_t'(MAX_RUN)) begin
        cur_count_next = cur_count + byte_t'(1);
      end else begin
        emit_mid           = 1'b1;
        pairs_emitted_next = pairs_emitted + len_t'(1);
        cur_value_next     = bytes.byte_value;
        cur_count_next     = byte_t'(1);
      end
    end

    final_pair.run_count = cur_count_next;
    final_pair.run_value = cur_value_next;
    final_pair.last_pair = 1'b1;
    final_pair.too_large = {({1'b0, pairs_emitted_next} + 17'd1), 3'b000} >
                           {4'b0000, eff_len};

    item_index_next = item_index + len_t'(1);
    if (last) begin
      emit_final         = ~stopped_next;
      cur_value_next     = '0;
      cur_count_next     = '0;
      pairs_emitted_next = '0;
      item_index_next    = '0;
      stopped_next       = 1'b0;
    end

    res0   = emit_mid ? mid_pair : final_pair;
    push_n = {1'b0, emit_mid} + {1'b0, emit_final};
    if (!accept) begin
      push_n = 2'd0;
    end
  end

  // Advance block state and block length
  always_ff @(posedge clk) begin
    if (rst) begin
      block_length  <= len_t'(1);
      cur_value     <= '0;
      cur_count     <= '0;
      pairs_emitted <= '0;
      item_index    <= '0;
      stopped       <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        block_length <= cfg.block_length;
      end
      if (accept) begin
        cur_value     <= cur_value_next;
        cur_count     <= cur_count_next;
        pairs_emitted <= pairs_emitted_next;
        item_index    <= item_index_next;
        stopped       <= stopped_next;
      end
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + Q_PTR_W'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      count <= count + Q_CNT_W'(push_n) - Q_CNT_W'(pop);
    end
  end

  // Write up to two pairs into the queue
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      queue[wr_ptr] <= res0;
    end
    if (push_n == 2'd2) begin
      queue[wr_ptr + Q_PTR_W'(1)] <= final_pair;
    end
  end

  // Drive the head of the queue
  assign pairs.valid     = (count != '0);
  assign pairs.run_count = queue[rd_ptr].run_count;
  assign pairs.run_value = queue[rd_ptr].run_value;
  assign pairs.last_pair = queue[rd_ptr].last_pair;
  assign pairs.too_large = queue[rd_ptr].too_large;

`include "byte_run_length_encoder_assert.svh"

  `BRLE_ASSERT_NOW(a_queue_bound, clk, rst, 1'b1, count <= Q_CNT_W'(Q_DEPTH))
  `BRLE_ASSERT_NOW(a_run_nonzero, clk, rst, pairs.valid, pairs.run_count != '0)
  `BRLE_ASSERT_NEXT(a_block_wraps, clk, rst, accept && last, item_index == '0)
  `BRLE_ASSERT_NOW(a_stop_midblock, clk, rst, stopped, item_index != '0)

endmodule
